>>> hdl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared widths, segment record and ring control record of the first-fit
// arena allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int ADDR_W    = 16;
  localparam int SIZE_W    = 17;
  localparam int ARENA_MAX = 65536;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              used;
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
  } seg_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic prev_we;
    seg_t tail;
    seg_t prev;
    seg_t init;
  } ring_ctrl_t;

endpackage

>>> hdl/first_fit_arena_allocator_unit.sv
// Each request (allocate or free) runs from acceptance to result while the
// segment ring of MAX_SEGS + 1 cells makes one full rotation past the head
// sequencer, one cell per cycle; the result is then delivered once the
// output can take it. One request is in work at a time; the next may be accepted
// while the previous result still waits on the output. A write of
// arena_bytes, taken only while no request is in work, reloads the arena
// as one free segment.
// ----------------------------------------------------------------------------
// first_fit_arena_allocator_unit
// First-fit arena allocator with coalescing, built as a rotating ring of
// segment cells in address order.
// ----------------------------------------------------------------------------
module first_fit_arena_allocator_unit #(
  parameter int HDR_BYTES = 32,
  parameter int MAX_SEGS  = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [ffa_pkg::SIZE_W-1:0]  req_size_i,
  input  logic [ffa_pkg::ADDR_W-1:0]  free_addr_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ffa_pkg::ADDR_W-1:0]  addr_o,
  output logic                        ok_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ffa_pkg::SIZE_W-1:0]  arena_bytes_i
);

  ffa_pkg::seg_t       cell_seg [MAX_SEGS+1];
  ffa_pkg::ring_ctrl_t ctrl;
  logic                busy, res_valid, res_ok, res_ready, start;
  logic [ffa_pkg::ADDR_W-1:0] res_addr;
  logic                out_valid_q, out_valid_d;
  logic [ffa_pkg::ADDR_W-1:0] addr_q;
  logic                ok_q;

  for (genvar gi = 0; gi <= MAX_SEGS; gi++) begin : g_cell
    ffa_pkg::seg_t nbr, ld;
    if (gi == MAX_SEGS) begin : g_tail
      assign nbr = ctrl.tail;
    end else if (gi == MAX_SEGS - 1) begin : g_prev
      assign nbr = ctrl.prev_we ? ctrl.prev : cell_seg[gi+1];
    end else begin : g_mid
      assign nbr = cell_seg[gi+1];
    end
    assign ld = (gi == 0) ? ctrl.init : '0;
    ffa_cell #(
      .RST_VALID (1'(gi == 0)),
      .RST_SIZE  ((gi == 0) ? (ffa_pkg::ARENA_MAX - HDR_BYTES) : 0)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (ctrl.shift),
      .load_i     (ctrl.load),
      .load_val_i (ld),
      .nbr_i      (nbr),
      .seg_o      (cell_seg[gi])
    );
  end

  assign cfg_ready_o = !busy;
  assign in_stall_o  = busy | cfg_valid_i;
  assign start       = in_valid_i & !in_stall_o;
  assign res_ready   = !out_valid_q || !out_stall_i;

  ffa_head #(
    .HDR_BYTES (HDR_BYTES),
    .MAX_SEGS  (MAX_SEGS)
  ) u_head (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .kind_i        (kind_i),
    .req_size_i    (req_size_i),
    .free_addr_i   (free_addr_i),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .arena_bytes_i (arena_bytes_i),
    .h0_i          (cell_seg[0]),
    .h1_i          (cell_seg[1]),
    .h2_i          (cell_seg[2]),
    .tl_i          (cell_seg[MAX_SEGS]),
    .res_ready_i   (res_ready),
    .ctrl_o        (ctrl),
    .busy_o        (busy),
    .res_valid_o   (res_valid),
    .res_addr_o    (res_addr),
    .res_ok_o      (res_ok)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      addr_q <= res_addr;
      ok_q   <= res_ok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign addr_o      = addr_q;
  assign ok_o        = ok_q;

`ifndef SYNTH
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy)
    else $error("request accepted but sequencer not busy");

  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ok_o) |-> (addr_o != '0))
    else $error("granted or freed request with null offset");

  a_ring_tail_spare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (!cell_seg[MAX_SEGS].valid && cell_seg[0].valid))
    else $error("segment ring out of order at rest");
`endif

endmodule

>>> hdl/ffa_cell.sv
// ----------------------------------------------------------------------------
// ffa_cell
// One ring cell: holds one segment record and takes its neighbor's record
// on every shift.
// ----------------------------------------------------------------------------
module ffa_cell #(
  parameter logic RST_VALID = 1'b0,
  parameter int   RST_SIZE  = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  logic          load_i,
  input  ffa_pkg::seg_t load_val_i,
  input  ffa_pkg::seg_t nbr_i,
  output ffa_pkg::seg_t seg_o
);

  ffa_pkg::seg_t seg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q.valid <= RST_VALID;
      seg_q.used  <= 1'b0;
      seg_q.start <= '0;
      seg_q.size  <= ffa_pkg::SIZE_W'(RST_SIZE);
    end else if (load_i) begin
      seg_q <= load_val_i;
    end else if (shift_i) begin
      seg_q <= nbr_i;
    end
  end

  assign seg_o = seg_q;

endmodule

>>> hdl/ffa_head.sv
// ----------------------------------------------------------------------------
// ffa_head
// Request sequencer at the head of the ring: matches, splits and merges
// segments as they pass, and keeps the result and the segment count.
// ----------------------------------------------------------------------------
module ffa_head #(
  parameter int HDR_BYTES = 32,
  parameter int MAX_SEGS  = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        kind_i,
  input  logic [ffa_pkg::SIZE_W-1:0]  req_size_i,
  input  logic [ffa_pkg::ADDR_W-1:0]  free_addr_i,
  input  logic                        cfg_we_i,
  input  logic [ffa_pkg::SIZE_W-1:0]  arena_bytes_i,
  input  ffa_pkg::seg_t               h0_i,
  input  ffa_pkg::seg_t               h1_i,
  input  ffa_pkg::seg_t               h2_i,
  input  ffa_pkg::seg_t               tl_i,
  input  logic                        res_ready_i,
  output ffa_pkg::ring_ctrl_t         ctrl_o,
  output logic                        busy_o,
  output logic                        res_valid_o,
  output logic [ffa_pkg::ADDR_W-1:0]  res_addr_o,
  output logic                        res_ok_o
);

  localparam int TW = $clog2(MAX_SEGS + 1);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [TW-1:0] LAST_T   = TW'(MAX_SEGS);
  localparam logic [TW:0]   LAST_X   = (TW + 1)'(MAX_SEGS);
  localparam logic [TW-1:0] MAX_CNT  = TW'(MAX_SEGS);
  localparam logic [ffa_pkg::ADDR_W:0]   HDR_A = (ffa_pkg::ADDR_W + 1)'(HDR_BYTES);
  localparam logic [ffa_pkg::SIZE_W-1:0] HDR_S = ffa_pkg::SIZE_W'(HDR_BYTES);
  localparam logic [ffa_pkg::SIZE_W-1:0] MIN_A = ffa_pkg::SIZE_W'(HDR_BYTES + 1);
  localparam logic [ffa_pkg::SIZE_W-1:0] MAX_A = ffa_pkg::SIZE_W'(ffa_pkg::ARENA_MAX);

  logic [1:0]                  st_q, st_d;
  logic [TW-1:0]               t_q, t_d;
  logic [TW-1:0]               cnt_q, cnt_d;
  logic                        kind_q, kind_d;
  logic [ffa_pkg::SIZE_W-1:0]  req_q, req_d;
  logic [ffa_pkg::ADDR_W-1:0]  faddr_q, faddr_d;
  logic                        found_q, found_d;
  logic [1:0]                  skip_q, skip_d;
  ffa_pkg::seg_t               carry_q, carry_d;
  logic                        carry_on_q, carry_on_d;
  logic [ffa_pkg::ADDR_W-1:0]  addr_q, addr_d;
  logic                        ok_q, ok_d;

  logic [ffa_pkg::ADDR_W:0]    h0_sum;
  logic [ffa_pkg::SIZE_W-1:0]  rest, msize, arena;
  logic                        a_hit, f_hit, split, nm, pm, use_skip;
  logic [1:0]                  sk_now;
  ffa_pkg::seg_t               seg_tmp;

  always_comb begin
    st_d       = st_q;
    t_d        = t_q;
    cnt_d      = cnt_q;
    kind_d     = kind_q;
    req_d      = req_q;
    faddr_d    = faddr_q;
    found_d    = found_q;
    skip_d     = skip_q;
    carry_d    = carry_q;
    carry_on_d = carry_on_q;
    addr_d     = addr_q;
    ok_d       = ok_q;
    ctrl_o     = '0;
    ctrl_o.tail = h0_i;
    res_valid_o = 1'b0;
    use_skip   = 1'b0;
    sk_now     = skip_q;
    seg_tmp    = h0_i;

    h0_sum = {1'b0, h0_i.start} + HDR_A;
    rest   = h0_i.size - req_q;
    a_hit  = (kind_q == ffa_pkg::KIND_ALLOC) && (req_q != '0) && h0_i.valid &&
             !h0_i.used && (h0_i.size >= req_q);
    split  = (rest > HDR_S) && (cnt_q < MAX_CNT);
    f_hit  = (kind_q == ffa_pkg::KIND_FREE) && (faddr_q != '0) && h0_i.valid &&
             h0_i.used && (h0_sum == {1'b0, faddr_q});
    nm     = h1_i.valid && !h1_i.used;
    pm     = (t_q != '0) && tl_i.valid && !tl_i.used;
    msize  = h0_i.size + (nm ? (h1_i.size + HDR_S) : '0);

    arena = arena_bytes_i;
    if (arena < MIN_A) arena = MIN_A;
    if (arena > MAX_A) arena = MAX_A;

    case (st_q)
      ST_IDLE: begin
        if (cfg_we_i) begin
          ctrl_o.load       = 1'b1;
          ctrl_o.init.valid = 1'b1;
          ctrl_o.init.used  = 1'b0;
          ctrl_o.init.start = '0;
          ctrl_o.init.size  = arena - HDR_S;
          cnt_d = TW'(1);
        end else if (start_i) begin
          st_d       = ST_RUN;
          t_d        = '0;
          kind_d     = kind_i;
          req_d      = req_size_i;
          faddr_d    = free_addr_i;
          found_d    = 1'b0;
          skip_d     = 2'd0;
          carry_on_d = 1'b0;
          addr_d     = (kind_i == ffa_pkg::KIND_FREE) ? free_addr_i : '0;
          ok_d       = 1'b0;
        end
      end
      ST_RUN: begin
        ctrl_o.shift = 1'b1;
        t_d = t_q + TW'(1);
        if (t_q == LAST_T) st_d = ST_DONE;
        if (skip_q != 2'd0) begin
          use_skip = 1'b1;
        end else if (carry_on_q) begin
          ctrl_o.tail = carry_q;
          if (h0_i.valid) carry_d = h0_i;
          else carry_on_d = 1'b0;
        end else if (!found_q && a_hit) begin
          found_d = 1'b1;
          ok_d    = 1'b1;
          addr_d  = h0_sum[ffa_pkg::ADDR_W-1:0];
          seg_tmp.used = 1'b1;
          if (split) begin
            seg_tmp.size      = req_q;
            carry_d.valid     = 1'b1;
            carry_d.used      = 1'b0;
            carry_d.start     = ffa_pkg::ADDR_W'(h0_sum + req_q);
            carry_d.size      = rest - HDR_S;
            carry_on_d        = 1'b1;
            cnt_d             = cnt_q + TW'(1);
          end
          ctrl_o.tail = seg_tmp;
        end else if (!found_q && f_hit) begin
          found_d = 1'b1;
          ok_d    = 1'b1;
          if (pm) begin
            ctrl_o.prev_we   = 1'b1;
            ctrl_o.prev      = tl_i;
            ctrl_o.prev.size = tl_i.size + msize + HDR_S;
            sk_now   = nm ? 2'd2 : 2'd1;
            skip_d   = sk_now;
            use_skip = 1'b1;
            cnt_d    = cnt_q - TW'(sk_now);
          end else begin
            seg_tmp.used = 1'b0;
            seg_tmp.size = msize;
            ctrl_o.tail  = seg_tmp;
            skip_d = nm ? 2'd1 : 2'd0;
            cnt_d  = cnt_q - TW'(nm);
          end
        end
        if (use_skip) begin
          if (({1'b0, t_q} + (TW + 1)'(sk_now)) > LAST_X) ctrl_o.tail = '0;
          else ctrl_o.tail = (sk_now == 2'd1) ? h1_i : h2_i;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          res_valid_o = 1'b1;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      cnt_q      <= TW'(1);
      t_q        <= '0;
      found_q    <= 1'b0;
      skip_q     <= 2'd0;
      carry_on_q <= 1'b0;
    end else begin
      st_q       <= st_d;
      cnt_q      <= cnt_d;
      t_q        <= t_d;
      found_q    <= found_d;
      skip_q     <= skip_d;
      carry_on_q <= carry_on_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    req_q   <= req_d;
    faddr_q <= faddr_d;
    carry_q <= carry_d;
    addr_q  <= addr_d;
    ok_q    <= ok_d;
  end

  assign busy_o     = (st_q != ST_IDLE);
  assign res_addr_o = addr_q;
  assign res_ok_o   = ok_q;

endmodule

>>> verif/ffa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_checker
// Watches the request, result and arena-size channels of the first-fit arena
// allocator. Keeps its own segment list, predicts each result and compares it
// field by field against the block's output in order.
// ----------------------------------------------------------------------------
module ffa_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic                       kind_i,
  input  logic [ffa_pkg::SIZE_W-1:0] req_size_i,
  input  logic [ffa_pkg::ADDR_W-1:0] free_addr_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [ffa_pkg::ADDR_W-1:0] addr_i,
  input  logic                       ok_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [ffa_pkg::SIZE_W-1:0] arena_bytes_i,
  output int                         fail_cnt_o,
  output int                         pending_o
);

  localparam int HDR  = 32;
  localparam int NSEG = 64;

  typedef struct packed {
    logic [ffa_pkg::ADDR_W-1:0] addr;
    logic                       ok;
  } grant_t;

  int  seg_base [NSEG];
  int  seg_len  [NSEG];
  bit  seg_busy [NSEG];
  int  seg_nxt  [NSEG];
  int  seg_prv  [NSEG];
  bit  seg_live [NSEG];
  grant_t grants_q[$];
  int mism;

  function automatic void arena_init(int bytes);
    int a;
    a = bytes;
    if (a < HDR + 1) a = HDR + 1;
    if (a > ffa_pkg::ARENA_MAX) a = ffa_pkg::ARENA_MAX;
    for (int i = 0; i < NSEG; i++) begin
      seg_base[i] = 0; seg_len[i] = 0; seg_busy[i] = 0;
      seg_nxt[i] = 0; seg_prv[i] = 0; seg_live[i] = 0;
    end
    seg_len[0] = a - HDR;
    seg_nxt[0] = NSEG;
    seg_prv[0] = NSEG;
    seg_live[0] = 1;
  endfunction

  function automatic void retire(int s);
    seg_live[s] = 0; seg_base[s] = 0; seg_len[s] = 0;
    seg_busy[s] = 0; seg_nxt[s] = 0; seg_prv[s] = 0;
  endfunction

  function automatic int carve(int req);
    int n, rest, s, nx;
    n = 0;
    if (req == 0) return 0;
    for (int k = 0; k < NSEG && n < NSEG; k++) begin
      if (!seg_busy[n] && seg_len[n] >= req) begin
        rest = seg_len[n] - req;
        seg_busy[n] = 1;
        if (rest > HDR) begin
          s = NSEG;
          for (int i = NSEG - 1; i >= 0; i--) if (!seg_live[i]) s = i;
          if (s < NSEG) begin
            nx = seg_nxt[n];
            seg_live[s] = 1;
            seg_base[s] = seg_base[n] + HDR + req;
            seg_len[s]  = rest - HDR;
            seg_busy[s] = 0;
            seg_prv[s]  = n;
            seg_nxt[s]  = nx;
            if (nx < NSEG) seg_prv[nx] = s;
            seg_len[n] = req;
            seg_nxt[n] = s;
          end
        end
        return (seg_base[n] + HDR) & 16'hFFFF;
      end
      n = seg_nxt[n];
    end
    return 0;
  endfunction

  function automatic bit give_back(int addr);
    int n, nx, nn, pv;
    n = 0;
    if (addr == 0) return 0;
    for (int k = 0; k < NSEG && n < NSEG; k++) begin
      if (seg_busy[n] && seg_base[n] + HDR == addr) begin
        nx = seg_nxt[n];
        seg_busy[n] = 0;
        if (nx < NSEG && !seg_busy[nx]) begin
          nn = seg_nxt[nx];
          seg_len[n] += seg_len[nx] + HDR;
          seg_nxt[n] = nn;
          if (nn < NSEG) seg_prv[nn] = n;
          retire(nx);
        end
        pv = seg_prv[n];
        if (pv < NSEG && !seg_busy[pv]) begin
          nn = seg_nxt[n];
          seg_len[pv] += seg_len[n] + HDR;
          seg_nxt[pv] = nn;
          if (nn < NSEG) seg_prv[nn] = pv;
          retire(n);
        end
        return 1;
      end
      n = seg_nxt[n];
    end
    return 0;
  endfunction

  assign pending_o = grants_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    grant_t g, want;
    int a;
    if (!rst_ni) begin
      arena_init(ffa_pkg::ARENA_MAX);
      grants_q.delete();
      fail_cnt_o <= 0;
      mism = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) arena_init(int'(arena_bytes_i));
      if (in_valid_i && !in_stall_i) begin
        if (kind_i == ffa_pkg::KIND_ALLOC) begin
          a = carve(int'(req_size_i));
          g.addr = a[ffa_pkg::ADDR_W-1:0];
          g.ok = (a != 0);
        end else begin
          g.addr = free_addr_i;
          g.ok = give_back(int'(free_addr_i));
        end
        grants_q.push_back(g);
      end
      if (out_valid_i && !out_stall_i) begin
        if (grants_q.size() == 0) begin
          mism++;
          if (mism <= 10) $display("unexpected result addr=%0d ok=%0d", addr_i, ok_i);
        end else begin
          want = grants_q.pop_front();
          if (want.addr !== addr_i || want.ok !== ok_i) begin
            mism++;
            if (mism <= 10)
              $display("mismatch: expected addr=%0d ok=%0d, got addr=%0d ok=%0d",
                       want.addr, want.ok, addr_i, ok_i);
          end
        end
      end
      fail_cnt_o <= mism;
    end
  end
endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus top for the first-fit arena allocator: directed corner requests,
// then random allocate/free traffic over several arena sizes, with random
// idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

  logic                       clk_i = 0;
  logic                       rst_ni = 0;
  logic                       in_valid_i = 0;
  logic                       in_stall_o;
  logic                       kind_i = 0;
  logic [ffa_pkg::SIZE_W-1:0] req_size_i = 0;
  logic [ffa_pkg::ADDR_W-1:0] free_addr_i = 0;
  logic                       out_valid_o;
  logic                       out_stall_i = 0;
  logic [ffa_pkg::ADDR_W-1:0] addr_o;
  logic                       ok_o;
  logic                       cfg_valid_i = 0;
  logic                       cfg_ready_o;
  logic [ffa_pkg::SIZE_W-1:0] arena_bytes_i = 0;
  int                         fail_cnt, pending;

  bit  idle_en = 1;
  bit  hold_req = 0;
  int  sent = 0, recvd = 0, granted = 0, cfg_writes = 0, quiet = 0;
  logic [ffa_pkg::ADDR_W-1:0] live_q[$];
  logic kinds_q[$];

  first_fit_arena_allocator_unit uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .req_size_i, .free_addr_i,
    .out_valid_o, .out_stall_i, .addr_o, .ok_o, .cfg_valid_i, .cfg_ready_o,
    .arena_bytes_i
  );

  ffa_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .kind_i, .req_size_i,
    .free_addr_i, .out_valid_i(out_valid_o), .out_stall_i, .addr_i(addr_o),
    .ok_i(ok_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .arena_bytes_i,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // track granted offsets and end the run as failed if traffic stops
  always @(posedge clk_i) begin
    logic k;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) kinds_q.push_back(kind_i);
      if (out_valid_o && !out_stall_i) begin
        recvd++;
        k = kinds_q.pop_front();
        if (k == ffa_pkg::KIND_ALLOC && ok_o) begin
          live_q.push_back(addr_o);
          granted++;
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
      if (quiet >= 5000) begin
        $display("first_fit_arena_allocator_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold = 0;
        out_stall_i <= 1;
        while (hold < 400) begin
          @(posedge clk_i);
          hold++;
        end
        hold_req = 0;
        out_stall_i <= 0;
      end else begin
        out_stall_i <= idle_en && ($urandom_range(99) < 21);
      end
    end
  end

  task automatic send(logic k, logic [ffa_pkg::SIZE_W-1:0] sz,
                      logic [ffa_pkg::ADDR_W-1:0] fa);
    in_valid_i <= 1;
    kind_i <= k;
    req_size_i <= sz;
    free_addr_i <= fa;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
    if (idle_en && $urandom_range(99) < 21) begin
      in_valid_i <= 0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (recvd != sent) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic set_arena(logic [ffa_pkg::SIZE_W-1:0] v);
    cfg_valid_i <= 1;
    arena_bytes_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    cfg_writes++;
    live_q.delete();
  endtask

  task automatic random_traffic(int n, int max_sz);
    int pick;
    logic [ffa_pkg::SIZE_W-1:0] sz;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        sz = (pick < 4) ? ffa_pkg::SIZE_W'($urandom) :
                          ffa_pkg::SIZE_W'($urandom_range(max_sz, 1));
        send(ffa_pkg::KIND_ALLOC, sz, ffa_pkg::ADDR_W'($urandom));
      end else if (pick < 90 && live_q.size() > 0) begin
        pick = $urandom_range(live_q.size() - 1);
        send(ffa_pkg::KIND_FREE, ffa_pkg::SIZE_W'($urandom), live_q[pick]);
        live_q.delete(pick);
      end else begin
        send(ffa_pkg::KIND_FREE, ffa_pkg::SIZE_W'($urandom),
             ($urandom_range(9) == 0) ? '0 : ffa_pkg::ADDR_W'($urandom));
      end
    end
  endtask

  initial begin
    logic [ffa_pkg::SIZE_W-1:0] sizes[6];
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed corners on the reset-size arena
    send(ffa_pkg::KIND_ALLOC, 0, '1);
    send(ffa_pkg::KIND_ALLOC, 17'd65536, 0);
    send(ffa_pkg::KIND_ALLOC, 17'h1FFFF, 0);
    send(ffa_pkg::KIND_ALLOC, 17'd65504, 0);
    send(ffa_pkg::KIND_FREE, 17'h1FFFF, 16'd32);
    send(ffa_pkg::KIND_FREE, 0, 16'd32);
    send(ffa_pkg::KIND_FREE, 0, 0);
    send(ffa_pkg::KIND_FREE, 0, 16'hFFFF);
    send(ffa_pkg::KIND_ALLOC, 1, 0);
    send(ffa_pkg::KIND_ALLOC, 100, 0);
    send(ffa_pkg::KIND_ALLOC, 64, 0);
    send(ffa_pkg::KIND_FREE, 0, 16'd65);
    send(ffa_pkg::KIND_FREE, 0, 16'd32);
    send(ffa_pkg::KIND_FREE, 0, 16'd197);
    send(ffa_pkg::KIND_ALLOC, 33, 0);
    send(ffa_pkg::KIND_ALLOC, 32, 0);
    drain();
    live_q.delete();
    set_arena(17'd33);
    send(ffa_pkg::KIND_ALLOC, 2, 0);
    send(ffa_pkg::KIND_ALLOC, 1, 0);
    send(ffa_pkg::KIND_ALLOC, 1, 0);
    send(ffa_pkg::KIND_FREE, 0, 16'd32);
    drain();

    sizes = '{17'd65536, 17'd0, 17'd1000, 17'h1FFFF, 17'd33, 17'(0)};
    sizes[5] = ffa_pkg::SIZE_W'($urandom_range(65536, 34));
    for (int p = 0; p < 6; p++) begin
      set_arena(sizes[p]);
      idle_en = (p != 2);
      if (p == 0) begin
        hold_req = 1;
        random_traffic(60, 200);
      end
      random_traffic(230, (p == 0 || p == 3) ? 300 : 600);
      drain();
    end

    $display("covered %0d requests, %0d grants, %0d arena size writes",
             sent, granted, cfg_writes);
    if (fail_cnt == 0 && pending == 0)
      $display("first_fit_arena_allocator_unit verification clean");
    else
      $display("first_fit_arena_allocator_unit verification failed");
    $finish;
  end
endmodule

>>> sim.f
hdl/ffa_pkg.sv
hdl/ffa_cell.sv
hdl/ffa_head.sv
hdl/first_fit_arena_allocator_unit.sv
verif/ffa_checker.sv
verif/tb.sv
